[hw/rtl/qau_pkg.sv]
// ---------------------------------------------------------------------------
// qau_pkg
// Shared widths, opcodes, sideband type and rounding helpers for the
// quaternion arithmetic unit.
// ---------------------------------------------------------------------------
package qau_pkg;

  // Field widths (signed Q4.12 data)
  localparam int DW    = 16;
  localparam int FB    = 12;
  localparam int KW    = 3;
  localparam int RSW   = 2;
  // Exact sum of products, sum of squares, root, quotient widths
  localparam int ACC_W = 2 * DW + 3;
  localparam int SW    = 2 * DW + 1;
  localparam int NS    = DW + 1;
  localparam int NW    = DW + 1;
  localparam int QB    = FB + 2;
  localparam int CW    = NW + QB;

  typedef enum logic [KW-1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_CONJ,
    OP_NORM,
    OP_NORMALIZE,
    OP_ROW
  } kind_e;

  typedef logic signed [DW-1:0] data_t;

  // Item context carried alongside the root and divide pipelines
  typedef struct packed {
    logic [KW-1:0]        kind;
    logic [3:0][DW-1:0]   res;
    logic                 sat;
    logic [3:0][DW-1:0]   a;
  } side_t;

  typedef struct packed {
    logic          flag;
    logic [DW-1:0] val;
  } sat_t;

  localparam logic signed [ACC_W-1:0] SMAX =
    {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  // Clip to the signed data range
  function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v > SMAX) begin
      r.flag = 1'b1;
      r.val  = SMAX[DW-1:0];
    end else if (v < SMIN) begin
      r.flag = 1'b1;
      r.val  = SMIN[DW-1:0];
    end else begin
      r.flag = 1'b0;
      r.val  = v[DW-1:0];
    end
    return r;
  endfunction

  // Round half up to FB fraction bits, then clip
  function automatic sat_t round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + HALF) >>> FB;
    return sat_word(t);
  endfunction

endpackage

[hw/rtl/qau_if.sv]
// ---------------------------------------------------------------------------
// qau_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface qau_in_if;
  import qau_pkg::*;
  logic                valid;
  logic                ready;
  logic [KW-1:0]       kind;
  logic signed [DW-1:0] a_w;
  logic signed [DW-1:0] a_x;
  logic signed [DW-1:0] a_y;
  logic signed [DW-1:0] a_z;
  logic signed [DW-1:0] b_w;
  logic signed [DW-1:0] b_x;
  logic signed [DW-1:0] b_y;
  logic signed [DW-1:0] b_z;
  logic [RSW-1:0]      row_select;

  modport source (output valid, kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  row_select, input ready);
  modport sink   (input valid, kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  row_select, output ready);
endinterface

interface qau_out_if;
  import qau_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [DW-1:0] res_0;
  logic signed [DW-1:0] res_1;
  logic signed [DW-1:0] res_2;
  logic signed [DW-1:0] res_3;
  logic [DW-1:0]       magnitude;
  logic                saturated;
  logic                divide_by_zero;

  modport source (output valid, res_0, res_1, res_2, res_3, magnitude, saturated,
                  divide_by_zero, input ready);
  modport sink   (input valid, res_0, res_1, res_2, res_3, magnitude, saturated,
                  divide_by_zero, output ready);
endinterface

[hw/rtl/qau_arith.sv]
// ---------------------------------------------------------------------------
// qau_arith
// Three-stage front end: product array, exact sums of products, then
// rounding and clipping. Also forms the sum of squares of A (of A_i * B_i for multiply).
// ---------------------------------------------------------------------------
module qau_arith (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [qau_pkg::KW-1:0]     kind_i,
  input  logic [3:0][qau_pkg::DW-1:0] a_i,
  input  logic [3:0][qau_pkg::DW-1:0] b_i,
  input  logic [qau_pkg::RSW-1:0]    row_i,
  output logic                       valid_o,
  output qau_pkg::side_t             side_o,
  output logic [qau_pkg::SW-1:0]     ssq_o
);
  import qau_pkg::*;

  localparam logic signed [ACC_W-1:0] ONE2 = ACC_W'(1) <<< (2 * FB);

  // Stage 1 registers
  logic                    v1_q;
  logic [KW-1:0]           kind1_q;
  logic [RSW-1:0]          row1_q;
  data_t                   a1_q [4];
  data_t                   b1_q [4];
  logic signed [2*DW-1:0]  p1_q [4][4];

  // Stage 2 registers
  logic                    v2_q;
  logic [KW-1:0]           kind2_q;
  logic [3:0][DW-1:0]      a2_q;
  logic signed [ACC_W-1:0] acc2_q [4];
  logic [SW-1:0]           ssq2_q;

  // Stage 3 registers
  logic                    v3_q;
  side_t                   side3_q;
  logic [SW-1:0]           ssq3_q;

  logic signed [ACC_W-1:0] pe [4][4];
  logic signed [ACC_W-1:0] acc_d [4];
  logic [SW-1:0]           ssq_d;
  logic signed [ACC_W-1:0] ae [4];
  logic signed [ACC_W-1:0] be [4];
  side_t                   side_d;
  sat_t                    rs;

  // Stage 1: all products A_i * M_j, M is B for multiply else A
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q <= kind_i;
      row1_q  <= row_i;
      for (int i = 0; i < 4; i++) begin
        a1_q[i] <= $signed(a_i[i]);
        b1_q[i] <= $signed(b_i[i]);
        for (int j = 0; j < 4; j++) begin
          p1_q[i][j] <= $signed(a_i[i]) *
                        $signed((kind_i == OP_MUL) ? b_i[j] : a_i[j]);
        end
      end
    end
  end

  // Stage 2: exact sums
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ae[i] = ACC_W'(a1_q[i]);
      be[i] = ACC_W'(b1_q[i]);
      acc_d[i] = '0;
      for (int j = 0; j < 4; j++) begin
        pe[i][j] = ACC_W'(p1_q[i][j]);
      end
    end
    ssq_d = SW'($unsigned(p1_q[0][0])) + SW'($unsigned(p1_q[1][1])) +
            SW'($unsigned(p1_q[2][2])) + SW'($unsigned(p1_q[3][3]));
    case (kind1_q)
      OP_ADD: begin
        for (int i = 0; i < 4; i++) acc_d[i] = (ae[i] + be[i]) <<< FB;
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) acc_d[i] = (ae[i] - be[i]) <<< FB;
      end
      OP_MUL: begin
        acc_d[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
        acc_d[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
        acc_d[2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
        acc_d[3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
      end
      OP_CONJ: begin
        acc_d[0] = ae[0] <<< FB;
        for (int i = 1; i < 4; i++) acc_d[i] = (-ae[i]) <<< FB;
      end
      OP_ROW: begin
        case (row1_q)
          2'd0: begin
            acc_d[0] = ONE2 - (pe[2][2] <<< 1) - (pe[3][3] <<< 1);
            acc_d[1] = (pe[1][2] <<< 1) - (pe[3][0] <<< 1);
            acc_d[2] = (pe[1][3] <<< 1) + (pe[2][0] <<< 1);
          end
          2'd1: begin
            acc_d[0] = (pe[1][2] <<< 1) + (pe[3][0] <<< 1);
            acc_d[1] = ONE2 - (pe[1][1] <<< 1) - (pe[3][3] <<< 1);
            acc_d[2] = (pe[2][3] <<< 1) - (pe[1][0] <<< 1);
          end
          2'd2: begin
            acc_d[0] = (pe[1][3] <<< 1) - (pe[2][0] <<< 1);
            acc_d[1] = (pe[2][3] <<< 1) + (pe[1][0] <<< 1);
            acc_d[2] = ONE2 - (pe[1][1] <<< 1) - (pe[2][2] <<< 1);
          end
          default: acc_d[3] = ONE2;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind2_q <= kind1_q;
      ssq2_q  <= ssq_d;
      for (int i = 0; i < 4; i++) begin
        acc2_q[i] <= acc_d[i];
        a2_q[i]   <= a1_q[i];
      end
    end
  end

  // Stage 3: round and clip each lane
  always_comb begin
    side_d      = '0;
    side_d.kind = kind2_q;
    side_d.a    = a2_q;
    for (int i = 0; i < 4; i++) begin
      rs = round_sat(acc2_q[i]);
      side_d.res[i] = rs.val;
      side_d.sat    = side_d.sat | rs.flag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side3_q <= side_d;
      ssq3_q  <= ssq2_q;
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side3_q;
  assign ssq_o   = ssq3_q;

endmodule

[hw/rtl/qau_sqrt.sv]
// ---------------------------------------------------------------------------
// qau_sqrt
// Pipelined integer square root, one result bit per stage, followed by a
// round-to-nearest stage.
// ---------------------------------------------------------------------------
module qau_sqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  qau_pkg::side_t         side_i,
  input  logic [qau_pkg::SW-1:0] ssq_i,
  output logic                   valid_o,
  output qau_pkg::side_t         side_o,
  output logic [qau_pkg::NW-1:0] root_o
);
  import qau_pkg::*;

  localparam int XW = SW + 1;

  logic          v_q  [0:NS];
  side_t         sd_q [0:NS];
  logic [XW-1:0] x_q  [0:NS];
  logic [XW-1:0] r_q  [0:NS];
  logic          vr_q;
  side_t         sdr_q;
  logic [NW-1:0] root_q;

  // Entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
      vr_q   <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      vr_q   <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= side_i;
      x_q[0]  <= XW'(ssq_i);
      r_q[0]  <= '0;
    end
  end

  // One trial subtract per stage, highest power of four first
  for (genvar k = 0; k < NS; k++) begin : g_iter
    localparam logic [XW-1:0] BIT = XW'(1) << (2 * (NS - 1 - k));
    logic [XW-1:0] trial;
    assign trial = r_q[k] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[k+1] <= sd_q[k];
        if (x_q[k] >= trial) begin
          x_q[k+1] <= x_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + BIT;
        end else begin
          x_q[k+1] <= x_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
      end
    end
  end

  // Round: bump when the remainder exceeds the root
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sdr_q  <= sd_q[NS];
      root_q <= r_q[NS][NW-1:0] + NW'(x_q[NS] > r_q[NS]);
    end
  end

  assign valid_o = vr_q;
  assign side_o  = sdr_q;
  assign root_o  = root_q;

endmodule

[hw/rtl/qau_div.sv]
// ---------------------------------------------------------------------------
// qau_div
// Four-lane pipelined restoring divider: |A_i| * 1.0 plus half the norm,
// divided by the norm, one quotient bit per stage.
// ---------------------------------------------------------------------------
module qau_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  qau_pkg::side_t                side_i,
  input  logic [qau_pkg::NW-1:0]        root_i,
  output logic                          valid_o,
  output qau_pkg::side_t                side_o,
  output logic [qau_pkg::NW-1:0]        root_o,
  output logic [3:0][qau_pkg::QB-1:0]   quot_o,
  output logic [3:0]                    neg_o
);
  import qau_pkg::*;

  logic                 v_q   [0:QB];
  side_t                sd_q  [0:QB];
  logic [NW-1:0]        n_q   [0:QB];
  logic [3:0]           neg_q [0:QB];
  logic [3:0][CW-1:0]   rem_q [0:QB];
  logic [3:0][QB-1:0]   q_q   [0:QB];

  logic [3:0][CW-1:0]   dvd_d;
  logic [3:0]           neg_d;
  logic [DW-1:0]        mag_a;

  // Rounded dividend magnitude per lane
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      neg_d[l] = side_i.a[l][DW-1];
      mag_a    = neg_d[l] ? (~side_i.a[l] + DW'(1)) : side_i.a[l];
      dvd_d[l] = CW'({mag_a, {FB{1'b0}}}) + CW'(root_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0]  <= side_i;
      n_q[0]   <= root_i;
      neg_q[0] <= neg_d;
      rem_q[0] <= dvd_d;
      q_q[0]   <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [CW-1:0] dv;
    assign dv = CW'(n_q[k]) << (QB - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[k+1]  <= sd_q[k];
        n_q[k+1]   <= n_q[k];
        neg_q[k+1] <= neg_q[k];
        for (int l = 0; l < 4; l++) begin
          if (rem_q[k][l] >= dv) begin
            rem_q[k+1][l] <= rem_q[k][l] - dv;
            q_q[k+1][l]   <= {q_q[k][l][QB-2:0], 1'b1};
          end else begin
            rem_q[k+1][l] <= rem_q[k][l];
            q_q[k+1][l]   <= {q_q[k][l][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign valid_o = v_q[QB];
  assign side_o  = sd_q[QB];
  assign root_o  = n_q[QB];
  assign quot_o  = q_q[QB];
  assign neg_o   = neg_q[QB];

endmodule

[hw/rtl/quaternion_arithmetic_unit.sv]
// ---------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Signed fixed-point quaternion add, subtract, Hamilton product, conjugate,
// norm, normalize and rotation matrix row, fully pipelined.
// ---------------------------------------------------------------------------
// Stages in order: arithmetic front end, square root, divider, output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register waits to be taken.
// The stage count is set by the bit-per-stage square root and divider.
// Reset clears all valid bits; payload registers are not reset.
module quaternion_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  qau_in_if.sink       in_i,
  qau_out_if.source    out_o
);
  import qau_pkg::*;

  logic                en;
  logic [3:0][DW-1:0]  a_in;
  logic [3:0][DW-1:0]  b_in;

  logic                ar_valid;
  side_t               ar_side;
  logic [SW-1:0]       ar_ssq;

  logic                sq_valid;
  side_t               sq_side;
  logic [NW-1:0]       sq_root;

  logic                dv_valid;
  side_t               dv_side;
  logic [NW-1:0]       dv_root;
  logic [3:0][QB-1:0]  dv_quot;
  logic [3:0]          dv_neg;

  logic                out_valid_q;
  logic [3:0][DW-1:0]  res_q;
  logic [DW-1:0]       mag_q;
  logic                sat_q;
  logic                dz_q;

  logic [3:0][DW-1:0]  res_d;
  logic [DW-1:0]       mag_d;
  logic                sat_d;
  logic                dz_d;
  logic signed [ACC_W-1:0] qv;
  sat_t                qs;

  // Global advance: the pipeline moves unless a result sits untaken
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign a_in = {in_i.a_z, in_i.a_y, in_i.a_x, in_i.a_w};
  assign b_in = {in_i.b_z, in_i.b_y, in_i.b_x, in_i.b_w};

  qau_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .kind_i  (in_i.kind),
    .a_i     (a_in),
    .b_i     (b_in),
    .row_i   (in_i.row_select),
    .valid_o (ar_valid),
    .side_o  (ar_side),
    .ssq_o   (ar_ssq)
  );

  qau_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ar_valid),
    .side_i  (ar_side),
    .ssq_i   (ar_ssq),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  qau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .side_i  (sq_side),
    .root_i  (sq_root),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .root_o  (dv_root),
    .quot_o  (dv_quot),
    .neg_o   (dv_neg)
  );

  // Result assembly
  always_comb begin
    res_d = dv_side.res;
    sat_d = dv_side.sat;
    mag_d = '0;
    dz_d  = 1'b0;
    qv    = '0;
    qs    = '0;
    if (dv_side.kind == OP_NORM || dv_side.kind == OP_NORMALIZE) begin
      res_d = '0;
      mag_d = dv_root[DW] ? '1 : dv_root[DW-1:0];
      sat_d = dv_root[DW];
      if (dv_side.kind == OP_NORMALIZE) begin
        if (dv_root == '0) begin
          dz_d = 1'b1;
        end else begin
          for (int l = 0; l < 4; l++) begin
            qv = $signed(ACC_W'(dv_quot[l]));
            if (dv_neg[l]) qv = -qv;
            qs = sat_word(qv);
            res_d[l] = qs.val;
            sat_d    = sat_d | qs.flag;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      mag_q <= mag_d;
      sat_q <= sat_d;
      dz_q  <= dz_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.res_0          = res_q[0];
  assign out_o.res_1          = res_q[1];
  assign out_o.res_2          = res_q[2];
  assign out_o.res_3          = res_q[3];
  assign out_o.magnitude      = mag_q;
  assign out_o.saturated      = sat_q;
  assign out_o.divide_by_zero = dz_q;

`ifndef NO_ASSERTIONS
  // A waiting result holds the whole pipeline
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while output stalled");

  // Zero norm gives an all-zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.divide_by_zero |->
      out_o.magnitude == '0 && out_o.res_0 == '0 && out_o.res_1 == '0 &&
      out_o.res_2 == '0 && out_o.res_3 == '0)
    else $error("divide by zero with nonzero result");

  // Zero norm cannot clip anything
  a_dz_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.divide_by_zero |-> !out_o.saturated)
    else $error("divide by zero flagged together with saturation");
`endif

endmodule
